// File: src/cialu_pkg.sv
// ----------------------------------------------------------------------------
// cialu_pkg
// Shared types and codes for the checked integer ALU.
// ----------------------------------------------------------------------------
package cialu_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_IDIV = 3'd3,
      OP_MOD  = 3'd4,
      OP_NEG  = 3'd5,
      OP_ABS  = 3'd6,
      OP_WADD = 3'd7
   } cialu_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVF   = 2'd1;
   localparam logic [1:0] ST_UNDEF = 2'd2;

   typedef struct packed {
      cialu_op_type       opcode;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } cialu_req_type;

   typedef struct packed {
      logic signed [63:0] result;
      logic [1:0]         status;
   } cialu_rsp_type;

   // side information that travels with a request down the cell chain
   typedef struct packed {
      cialu_op_type op;
      logic         neg_r;
      logic         undef;
      logic [63:0]  pre_result;
      logic [1:0]   pre_status;
   } cialu_tag_type;

endpackage

// File: src/cialu_cell.sv
// ----------------------------------------------------------------------------
// cialu_cell
// One step of shift-add multiply or restoring divide, one bit per cell.
// ----------------------------------------------------------------------------
module cialu_cell #(
   parameter int W = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  cialu_pkg::cialu_tag_type tag_in,
   input  logic [2*W-1:0]          acc_in,
   input  logic [W-1:0]            shq_in,
   input  logic [W-1:0]            m_in,
   output logic                    valid_out,
   output cialu_pkg::cialu_tag_type tag_out,
   output logic [2*W-1:0]          acc_out,
   output logic [W-1:0]            shq_out,
   output logic [W-1:0]            m_out
);
   import cialu_pkg::*;

   logic                valid_ff;
   cialu_tag_type       tag_ff, tag_in_w;
   logic [2*W-1:0]      acc_ff, acc_in_w;
   logic [W-1:0]        shq_ff, shq_in_w;
   logic [W-1:0]        m_ff;
   logic [W:0]          trial;
   logic [W:0]          diff;
   logic                ge;

   always_comb begin
      trial = {acc_in[W-1:0], shq_in[W-1]};
      diff  = trial - {1'b0, m_in};
      ge    = ~diff[W];
      tag_in_w = tag_in;
      if (tag_in.op == OP_MUL) begin
         acc_in_w = {acc_in[2*W-2:0], 1'b0} + (shq_in[W-1] ? {{W{1'b0}}, m_in} : '0);
         shq_in_w = {shq_in[W-2:0], 1'b0};
      end else begin
         acc_in_w = {{W{1'b0}}, (ge ? diff[W-1:0] : trial[W-1:0])};
         shq_in_w = {shq_in[W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff <= tag_in_w;
      acc_ff <= acc_in_w;
      shq_ff <= shq_in_w;
      m_ff   <= m_in;
   end

   assign valid_out = valid_ff;
   assign tag_out   = tag_ff;
   assign acc_out   = acc_ff;
   assign shq_out   = shq_ff;
   assign m_out     = m_ff;

endmodule

// File: src/checked_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_unit
// Signed ALU with overflow and undefined-result status.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy is always low.
// Each request gives one response on rsp_valid, in request order, after
// passing through one entry stage, a chain of WORD_BITS cells that
// each resolve one multiplier or quotient bit, and one output stage. The
// response is held for a single cycle and cannot be stalled.
module checked_integer_alu_unit #(
   parameter int WORD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  cialu_pkg::cialu_req_type req_data,
   output logic                     rsp_valid,
   output cialu_pkg::cialu_rsp_type rsp_data,
   input  logic                     csr_we,
   input  logic                     csr_wdata
);
   import cialu_pkg::*;

   localparam int W = WORD_BITS;

   logic          compat_ff;
   logic [W-1:0]  a_raw, b_raw, a_c, b_c, a_s, b_s, min_w, ma, mb;
   logic [W:0]    ax, bx, sum_x, dif_x, neg_x;
   logic [W-1:0]  pre_r;
   logic [1:0]    pre_st;
   cialu_op_type  op;
   cialu_tag_type tag_e;

   logic          valid_c [W+1];
   cialu_tag_type tag_c   [W+1];
   logic [2*W-1:0] acc_c  [W+1];
   logic [W-1:0]  shq_c   [W+1];
   logic [W-1:0]  m_c     [W+1];

   logic [2*W-1:0] sp;
   logic [W-1:0]   q_r, rem_r;
   logic           mul_fit;
   cialu_rsp_type  rsp_ff, rsp_in;
   logic           rsp_valid_ff;

   function automatic logic fits_w(input logic [W:0] x, input logic c32);
      if (c32) begin
         fits_w = (x == (W+1)'($signed(x[31:0])));
      end else begin
         fits_w = (x[W] == x[W-1]);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         compat_ff <= 1'b0;
      end else if (csr_we) begin
         compat_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   always_comb begin
      op    = req_data.opcode;
      a_raw = req_data.operand_a[W-1:0];
      b_raw = req_data.operand_b[W-1:0];
      a_c   = compat_ff ? W'($signed(a_raw[31:0])) : a_raw;
      b_c   = compat_ff ? W'($signed(b_raw[31:0])) : b_raw;
      a_s   = (op == OP_MOD || op == OP_WADD) ? a_raw : a_c;
      b_s   = (op == OP_MOD || op == OP_WADD) ? b_raw : b_c;
      min_w = compat_ff ? W'($signed(32'h8000_0000)) : {1'b1, {(W-1){1'b0}}};
      ma    = a_s[W-1] ? W'(0) - a_s : a_s;
      mb    = b_s[W-1] ? W'(0) - b_s : b_s;
      ax    = {a_s[W-1], a_s};
      bx    = {b_s[W-1], b_s};
      sum_x = ax + bx;
      dif_x = ax - bx;
      neg_x = (W+1)'(0) - ax;
      pre_r  = '0;
      pre_st = ST_OK;
      case (op)
         OP_ADD: begin
            pre_r  = sum_x[W-1:0];
            pre_st = fits_w(sum_x, compat_ff) ? ST_OK : ST_OVF;
         end
         OP_SUB: begin
            pre_r  = dif_x[W-1:0];
            pre_st = fits_w(dif_x, compat_ff) ? ST_OK : ST_OVF;
         end
         OP_NEG: begin
            pre_r  = neg_x[W-1:0];
            pre_st = fits_w(neg_x, compat_ff) ? ST_OK : ST_OVF;
         end
         OP_ABS: begin
            pre_r  = a_s[W-1] ? neg_x[W-1:0] : a_s;
            pre_st = (!a_s[W-1] || fits_w(neg_x, compat_ff)) ? ST_OK : ST_OVF;
         end
         OP_WADD: begin
            pre_r = sum_x[W-1:0];
         end
         default: begin
            pre_r = '0;
         end
      endcase
      tag_e.op         = op;
      tag_e.neg_r      = (op == OP_MOD) ? a_s[W-1] : (a_s[W-1] ^ b_s[W-1]);
      tag_e.undef      = (b_s == '0) ||
                         (op == OP_IDIV && a_s == min_w && (&b_s));
      tag_e.pre_result = 64'($signed(pre_r));
      tag_e.pre_status = pre_st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c[0] <= 1'b0;
      end else begin
         valid_c[0] <= start;
      end
      tag_c[0] <= tag_e;
      acc_c[0] <= '0;
      shq_c[0] <= (op == OP_MUL) ? mb : ma;
      m_c[0]   <= (op == OP_MUL) ? ma : mb;
   end

   for (genvar i = 0; i < W; i++) begin : g_cell
      cialu_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_c[i]),
         .tag_in    (tag_c[i]),
         .acc_in    (acc_c[i]),
         .shq_in    (shq_c[i]),
         .m_in      (m_c[i]),
         .valid_out (valid_c[i+1]),
         .tag_out   (tag_c[i+1]),
         .acc_out   (acc_c[i+1]),
         .shq_out   (shq_c[i+1]),
         .m_out     (m_c[i+1])
      );
   end

   always_comb begin
      sp      = tag_c[W].neg_r ? (2*W)'(0) - acc_c[W] : acc_c[W];
      mul_fit = compat_ff ? (sp == (2*W)'($signed(sp[31:0])))
                          : (sp == (2*W)'($signed(sp[W-1:0])));
      q_r     = tag_c[W].neg_r ? W'(0) - shq_c[W] : shq_c[W];
      rem_r   = tag_c[W].neg_r ? W'(0) - acc_c[W][W-1:0] : acc_c[W][W-1:0];
      rsp_in.result = tag_c[W].pre_result;
      rsp_in.status = tag_c[W].pre_status;
      case (tag_c[W].op)
         OP_MUL: begin
            rsp_in.result = 64'($signed(sp[W-1:0]));
            rsp_in.status = mul_fit ? ST_OK : ST_OVF;
         end
         OP_IDIV: begin
            rsp_in.result = tag_c[W].undef ? 64'(0) : 64'($signed(q_r));
            rsp_in.status = tag_c[W].undef ? ST_UNDEF : ST_OK;
         end
         OP_MOD: begin
            rsp_in.result = tag_c[W].undef ? 64'(0) : 64'($signed(rem_r));
            rsp_in.status = tag_c[W].undef ? ST_UNDEF : ST_OK;
         end
         default: begin
            rsp_in.result = tag_c[W].pre_result;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_c[W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start, W+2))
      else $error("response without matching request");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_UNDEF) |-> (rsp_ff.result == 64'(0)))
      else $error("undefined result not zero");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == ST_OK || rsp_ff.status == ST_OVF ||
                        rsp_ff.status == ST_UNDEF))
      else $error("bad status code");

endmodule
